### design/ocp_pkg.sv
// Shared constants, types and tables for the orbit camera position block.
package ocp_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_BITS    = 5;
  localparam int CW           = 34;

  localparam logic [ANGLE_BITS-1:0] YAW_RESET =
    ANGLE_BITS'(64'd3 << (ANGLE_BITS - 2));
  localparam logic [ANGLE_BITS-1:0] PITCH_RESET =
    ANGLE_BITS'(((64'd1 << ANGLE_BITS) * 64'd20 + 64'd180) / 64'd360);

  localparam logic [15:0] SENSITIVITY_RESET = 16'd4660;
  localparam logic [31:0] RADIUS_RESET      = 32'd655360;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q30     = 34'sd1073741824;

  typedef enum logic [2:0] {
    REG_SENSITIVITY = 3'd0,
    REG_RADIUS      = 3'd1,
    REG_TARGET_X    = 3'd2,
    REG_TARGET_Y    = 3'd3,
    REG_TARGET_Z    = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_ANGLE,
    ST_CORDIC,
    ST_MUL,
    ST_DONE
  } ocp_state_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 flip;
  } cordic_vec_t;

  function automatic logic [31:0] atan_turn32(input logic [STEP_BITS-1:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd3;
      5'd29: a = 32'd1;
      5'd30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  function automatic logic signed [31:0] clamp_q30(input logic signed [CW-1:0] v);
    logic signed [31:0] r;
    if (v > ONE_Q30) begin
      r = 32'sd1073741824;
    end else if (v < -ONE_Q30) begin
      r = -32'sd1073741824;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### design/ocp_cordic_cell.sv
// One CORDIC rotation cell: rotate one vector by one table angle and register it.
module ocp_cordic_cell import ocp_pkg::*; (
  input  logic                 clk,
  input  logic [STEP_BITS-1:0] step,
  input  cordic_vec_t          cell_in,
  output cordic_vec_t          cell_out
);

  logic signed [CW-1:0] x_sh;
  logic signed [CW-1:0] y_sh;
  logic signed [CW-1:0] ang;
  cordic_vec_t          cell_next;

  always_comb begin
    x_sh = cell_in.x >>> step;
    y_sh = cell_in.y >>> step;
    ang  = signed'({{(CW-32){1'b0}}, atan_turn32(step)});
    cell_next.flip = cell_in.flip;
    if (!cell_in.z[CW-1]) begin
      cell_next.x = cell_in.x - y_sh;
      cell_next.y = cell_in.y + x_sh;
      cell_next.z = cell_in.z - ang;
    end else begin
      cell_next.x = cell_in.x + y_sh;
      cell_next.y = cell_in.y - x_sh;
      cell_next.z = cell_in.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    cell_out <= cell_next;
  end

endmodule

### design/ocp_cordic_row.sv
// Row of CORDIC cells giving sine and cosine of one angle in Q1.30.
module ocp_cordic_row import ocp_pkg::*; (
  input  logic                   clk,
  input  logic [ANGLE_BITS-1:0]  angle,
  output logic signed [31:0]     sin_q30,
  output logic signed [31:0]     cos_q30
);

  logic [31:0]          turn;
  logic [31:0]          turn_rot;
  logic                 flip;
  cordic_vec_t          chain [CORDIC_STEPS+1];
  logic signed [CW-1:0] x_fin;
  logic signed [CW-1:0] y_fin;

  always_comb begin
    turn     = {angle, {(32-ANGLE_BITS){1'b0}}};
    flip     = turn[31] ^ turn[30];
    turn_rot = flip ? (turn ^ 32'h8000_0000) : turn;
    chain[0].x    = CORDIC_GAIN;
    chain[0].y    = '0;
    chain[0].z    = signed'({{(CW-32){turn_rot[31]}}, turn_rot});
    chain[0].flip = flip;
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    ocp_cordic_cell u_cell (
      .clk      (clk),
      .step     (STEP_BITS'(g)),
      .cell_in  (chain[g]),
      .cell_out (chain[g+1])
    );
  end

  always_comb begin
    x_fin   = chain[CORDIC_STEPS].flip ? -chain[CORDIC_STEPS].x : chain[CORDIC_STEPS].x;
    y_fin   = chain[CORDIC_STEPS].flip ? -chain[CORDIC_STEPS].y : chain[CORDIC_STEPS].y;
    cos_q30 = clamp_q30(x_fin);
    sin_q30 = clamp_q30(y_fin);
  end

endmodule

### design/orbit_camera_position.sv
// Orbit camera position: mouse offsets to yaw/pitch and camera position on a sphere.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------------
//   input    | in_valid / in_stall     | x_offset, y_offset
//   output   | out_valid / out_stall   | yaw_angle, pitch_angle, pos_x, pos_y, pos_z
//   config   | cfg_we                  | cfg_index, cfg_data
//
// Each item passes through scale, angle update, the row of CORDIC cells, then six
// passes through the single shared multiplier; a new item is taken only after the
// result of the last one is loaded.
// Reset (rst, synchronous) restores the state, the angles and the config registers; nothing to clear.
// A result waits in the output registers while out_stall is high; the next item
// may be taken meanwhile and only stalls at its final load.
module orbit_camera_position import ocp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] x_offset,
  input  logic signed [15:0] y_offset,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        yaw_angle,
  output logic [15:0]        pitch_angle,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  ocp_state_t state;
  ocp_state_t state_next;

  logic [15:0]           sensitivity;
  logic [31:0]           orbit_radius;
  logic signed [31:0]    target_x;
  logic signed [31:0]    target_y;
  logic signed [31:0]    target_z;

  logic [ANGLE_BITS-1:0] yaw;
  logic [ANGLE_BITS-1:0] pitch;
  logic [STEP_BITS-1:0]  cnt;
  logic signed [15:0]    off_x;
  logic signed [15:0]    off_y;
  logic signed [32:0]    prod_x;
  logic signed [32:0]    prod_y;
  logic signed [32:0]    sum_x;
  logic signed [32:0]    sum_y;

  logic signed [31:0]    sin_yaw;
  logic signed [31:0]    cos_yaw;
  logic signed [31:0]    sin_pitch;
  logic signed [31:0]    cos_pitch;

  logic signed [32:0]    mul_a;
  logic signed [32:0]    mul_b;
  logic signed [65:0]    prod;
  logic signed [65:0]    rnd;
  logic signed [31:0]    ccx;
  logic signed [31:0]    ccz;
  logic signed [31:0]    tgt;
  logic signed [34:0]    pos_sum;
  logic signed [31:0]    pos_sat;
  logic signed [31:0]    px;
  logic signed [31:0]    py;
  logic signed [31:0]    pos_z_hold;
  logic [31:0]           yaw_turn;
  logic [31:0]           pitch_turn;
  logic                  out_load;

  ocp_cordic_row u_row_yaw (
    .clk     (clk),
    .angle   (yaw),
    .sin_q30 (sin_yaw),
    .cos_q30 (cos_yaw)
  );

  ocp_cordic_row u_row_pitch (
    .clk     (clk),
    .angle   (pitch),
    .sin_q30 (sin_pitch),
    .cos_q30 (cos_pitch)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        state_next = ST_ANGLE;
      end
      ST_ANGLE: begin
        state_next = ST_CORDIC;
      end
      ST_CORDIC: begin
        if (cnt == STEP_BITS'(CORDIC_STEPS - 1)) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (cnt == STEP_BITS'(5)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    sum_x = prod_x + 33'sd128;
    sum_y = prod_y + 33'sd128;

    case (cnt)
      5'd0: begin
        mul_a = 33'(cos_yaw);
        mul_b = 33'(cos_pitch);
      end
      5'd1: begin
        mul_a = 33'(sin_yaw);
        mul_b = 33'(cos_pitch);
      end
      5'd2: begin
        mul_a = signed'({1'b0, orbit_radius});
        mul_b = 33'(ccx);
      end
      5'd3: begin
        mul_a = signed'({1'b0, orbit_radius});
        mul_b = 33'(sin_pitch);
      end
      default: begin
        mul_a = signed'({1'b0, orbit_radius});
        mul_b = 33'(ccz);
      end
    endcase

    rnd = (prod + 66'sd536870912) >>> 30;

    case (cnt)
      5'd3:    tgt = target_x;
      5'd4:    tgt = target_y;
      default: tgt = target_z;
    endcase

    pos_sum = 35'(signed'(rnd[33:0])) + 35'(tgt);
    if (pos_sum > 35'sd2147483647) begin
      pos_sat = 32'sh7FFF_FFFF;
    end else if (pos_sum < -35'sd2147483648) begin
      pos_sat = 32'sh8000_0000;
    end else begin
      pos_sat = pos_sum[31:0];
    end

    yaw_turn   = {yaw, {(32-ANGLE_BITS){1'b0}}};
    pitch_turn = {pitch, {(32-ANGLE_BITS){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity  <= SENSITIVITY_RESET;
      orbit_radius <= RADIUS_RESET;
      target_x     <= '0;
      target_y     <= '0;
      target_z     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SENSITIVITY: sensitivity  <= cfg_data[15:0];
        REG_RADIUS:      orbit_radius <= cfg_data;
        REG_TARGET_X:    target_x     <= signed'(cfg_data);
        REG_TARGET_Y:    target_y     <= signed'(cfg_data);
        REG_TARGET_Z:    target_z     <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw       <= YAW_RESET;
      pitch     <= PITCH_RESET;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == ST_ANGLE) begin
        yaw   <= yaw + sum_x[ANGLE_BITS+7:8];
        pitch <= pitch - sum_y[ANGLE_BITS+7:8];
      end
      if ((state == ST_CORDIC && state_next == ST_MUL) ||
          (state == ST_MUL && state_next == ST_DONE)) begin
        cnt <= '0;
      end else if (state == ST_CORDIC || state == ST_MUL) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      off_x <= x_offset;
      off_y <= y_offset;
    end
    if (state == ST_SCALE) begin
      prod_x <= off_x * signed'({1'b0, sensitivity});
      prod_y <= off_y * signed'({1'b0, sensitivity});
    end
    if (state == ST_MUL) begin
      prod <= mul_a * mul_b;
      case (cnt)
        5'd1: ccx <= rnd[31:0];
        5'd2: ccz <= rnd[31:0];
        5'd3: px  <= pos_sat;
        5'd4: py  <= pos_sat;
        5'd5: pos_z_hold <= pos_sat;
        default: ;
      endcase
    end
    if (out_load) begin
      yaw_angle   <= yaw_turn[31:16];
      pitch_angle <= pitch_turn[31:16];
      pos_x       <= px;
      pos_y       <= py;
      pos_z       <= pos_z_hold;
    end
  end

endmodule

### tb/orbit_camera_position_test.sv
// Self-checking testbench for the orbit camera position block: directed and random moves.
`timescale 1ns / 1ps

typedef struct {
  logic [15:0]        yaw;
  logic [15:0]        pitch;
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic signed [31:0] pz;
} camera_view_t;

class orbit_ledger;
  localparam longint GAIN     = 64'sd652032874;
  localparam longint ONE_Q30  = 64'sd1073741824;
  localparam longint HALF_Q30 = 64'sd536870912;
  localparam int     STEPS    = 16;
  localparam longint ATAN_TURN [0:15] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861
  };

  longint       sens;
  longint       radius;
  longint       tx;
  longint       ty;
  longint       tz;
  logic [15:0]  yaw;
  logic [15:0]  pitch;
  camera_view_t expected_views[$];
  int           faults;

  function new();
    sens   = 4660;
    radius = 655360;
    tx     = 0;
    ty     = 0;
    tz     = 0;
    yaw    = 16'd49152;
    pitch  = 16'd3641;
    faults = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] data);
    case (ocp_pkg::cfg_reg_t'(idx))
      ocp_pkg::REG_SENSITIVITY: sens   = longint'(data[15:0]);
      ocp_pkg::REG_RADIUS:      radius = longint'(data);
      ocp_pkg::REG_TARGET_X:    tx     = longint'($signed(data));
      ocp_pkg::REG_TARGET_Y:    ty     = longint'($signed(data));
      ocp_pkg::REG_TARGET_Z:    tz     = longint'($signed(data));
      default: ;
    endcase
  endfunction

  function void sin_cos(logic [15:0] a, output longint s, output longint c);
    logic [31:0] t;
    bit          flip;
    longint      x;
    longint      y;
    longint      z;
    longint      nx;
    t = {a, 16'h0000};
    flip = (t[31:30] == 2'b01) || (t[31:30] == 2'b10);
    if (flip) begin
      t = t + 32'h8000_0000;
    end
    z = longint'($signed(t));
    x = GAIN;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ATAN_TURN[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ATAN_TURN[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = (x > ONE_Q30) ? ONE_Q30 : (x < -ONE_Q30) ? -ONE_Q30 : x;
    s = (y > ONE_Q30) ? ONE_Q30 : (y < -ONE_Q30) ? -ONE_Q30 : y;
  endfunction

  function logic signed [31:0] place_axis(longint tgt, longint term);
    longint v;
    v = tgt + ((radius * term + HALF_Q30) >>> 30);
    if (v > 64'sd2147483647) begin
      v = 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      v = -64'sd2147483648;
    end
    return v[31:0];
  endfunction

  function void take_move(logic signed [15:0] xo, logic signed [15:0] yo);
    longint       dx;
    longint       dy;
    longint       sy;
    longint       cy;
    longint       sp;
    longint       cp;
    camera_view_t v;
    dx = (longint'(xo) * sens + 128) >>> 8;
    dy = (longint'(yo) * sens + 128) >>> 8;
    yaw   = yaw + dx[15:0];
    pitch = pitch - dy[15:0];
    sin_cos(yaw, sy, cy);
    sin_cos(pitch, sp, cp);
    v.yaw   = yaw;
    v.pitch = pitch;
    v.px    = place_axis(tx, (cy * cp + HALF_Q30) >>> 30);
    v.py    = place_axis(ty, sp);
    v.pz    = place_axis(tz, (sy * cp + HALF_Q30) >>> 30);
    expected_views.push_back(v);
  endfunction

  function void check_view(camera_view_t got);
    camera_view_t want;
    if (expected_views.size() == 0) begin
      faults++;
      if (faults <= 10) begin
        $display("unexpected result: yaw %0d pitch %0d pos %0d %0d %0d",
                 got.yaw, got.pitch, got.px, got.py, got.pz);
      end
      return;
    end
    want = expected_views.pop_front();
    if (got.yaw !== want.yaw || got.pitch !== want.pitch || got.px !== want.px ||
        got.py !== want.py || got.pz !== want.pz) begin
      faults++;
      if (faults <= 10) begin
        $display("mismatch: expected yaw %0d pitch %0d pos %0d %0d %0d",
                 want.yaw, want.pitch, want.px, want.py, want.pz);
        $display("          actual   yaw %0d pitch %0d pos %0d %0d %0d",
                 got.yaw, got.pitch, got.px, got.py, got.pz);
      end
    end
  endfunction

  function int pending();
    return expected_views.size();
  endfunction
endclass

module orbit_camera_position_test;
  import ocp_pkg::*;

  localparam int LIMIT = 400000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] x_offset;
  logic signed [15:0] y_offset;
  logic               out_valid;
  logic               out_stall;
  logic [15:0]        yaw_angle;
  logic [15:0]        pitch_angle;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;

  orbit_ledger book = new();
  bit          calm;
  int          hold_left;
  int          cycles;

  orbit_camera_position dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .x_offset(x_offset), .y_offset(y_offset),
    .out_valid(out_valid), .out_stall(out_stall),
    .yaw_angle(yaw_angle), .pitch_angle(pitch_angle),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("orbit_camera_position_test NOT OK");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    camera_view_t got;
    if (!rst) begin
      if (cfg_we) begin
        book.write_reg(cfg_index, cfg_data);
      end
      if (in_valid && !in_stall) begin
        book.take_move(x_offset, y_offset);
      end
      if (out_valid && !out_stall) begin
        got.yaw   = yaw_angle;
        got.pitch = pitch_angle;
        got.px    = pos_x;
        got.py    = pos_y;
        got.pz    = pos_z;
        book.check_view(got);
      end
    end
  end

  // receiver: random stalls, or a long hold when requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = !calm && ($urandom_range(0, 99) < 14);
      end
    end
  end

  task automatic send_move(logic signed [15:0] xo, logic signed [15:0] yo);
    while (!calm && $urandom_range(0, 99) < 14) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    x_offset = xo;
    y_offset = yo;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // steer to absolute angles; assumes unit sensitivity
  task automatic aim(logic [15:0] yaw_to, logic [15:0] pitch_to);
    send_move($signed(yaw_to - book.yaw), $signed(book.pitch - pitch_to));
  endtask

  task automatic set_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (book.pending() != 0) @(negedge clk);
  endtask

  task automatic set_all(logic [15:0] s, logic [31:0] r, logic [31:0] x, logic [31:0] y,
                         logic [31:0] z);
    set_reg(REG_SENSITIVITY, {16'h0000, s});
    set_reg(REG_RADIUS, r);
    set_reg(REG_TARGET_X, x);
    set_reg(REG_TARGET_Y, y);
    set_reg(REG_TARGET_Z, z);
    set_reg(3'(REG_TARGET_Z) + 3'($urandom_range(1, 3)), $urandom);
  endtask

  function automatic logic [31:0] pick_target();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [15:0] pick_offset();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'($urandom);
      4, 5, 6, 7: return 16'($signed($urandom_range(0, 128)) - 64);
      8: begin
        case ($urandom_range(0, 4))
          0:       return 16'sh8000;
          1:       return 16'sh7FFF;
          2:       return -16'sd1;
          3:       return 16'sd1;
          default: return 16'sd0;
        endcase
      end
      default: return 16'sd0;
    endcase
  endfunction

  initial begin
    logic [15:0] s;
    logic [31:0] r;
    rst       = 1'b1;
    in_valid  = 1'b0;
    x_offset  = '0;
    y_offset  = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    calm      = 1'b0;
    hold_left = 0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // reset settings, field extremes
    send_move(16'sd0, 16'sd0);
    send_move(16'sh7FFF, 16'sh7FFF);
    send_move(16'sh8000, 16'sh8000);
    send_move(16'sh7FFF, 16'sh8000);
    send_move(16'sh8000, 16'sh7FFF);
    send_move(16'sd1, -16'sd1);
    send_move(-16'sd1, 16'sd1);
    drain();

    // quadrant edges and full-scale radius
    set_all(16'd256, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
    aim(16'd0, 16'd0);
    aim(16'd16384, 16'd16384);
    aim(16'd32768, 16'd32768);
    aim(16'd49152, 16'd49152);
    aim(16'd16383, 16'd16385);
    aim(16'd32767, 16'd49153);
    aim(16'd65535, 16'd65535);
    aim(16'd8192, 16'd57344);
    drain();

    // half-unit rounding, large radius, extreme targets
    set_all(16'd128, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_move(16'sd1, 16'sd1);
    send_move(-16'sd1, -16'sd1);
    send_move(16'sd3, -16'sd3);
    send_move(-16'sd3, 16'sd3);
    send_move(16'sd255, -16'sd255);
    drain();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: set_all(16'hFFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        1: set_all(16'h0000, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        2: set_all(16'h0001, 32'h0000_0001, 32'd0, 32'd0, 32'd0);
        default: begin
          s = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2000));
          r = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 32'h0100_0000);
          set_all(s, r, pick_target(), pick_target(), pick_target());
        end
      endcase
      calm = (p == 4);
      if (p == 6) begin
        hold_left = 400;
      end
      repeat (125) send_move(pick_offset(), pick_offset());
      drain();
    end

    calm = 1'b0;
    repeat (64) @(negedge clk);
    if (book.faults == 0 && book.pending() == 0) begin
      $display("orbit_camera_position_test OK");
    end else begin
      $display("orbit_camera_position_test NOT OK");
    end
    $finish;
  end
endmodule
